>>> rtl/ach_pkg.sv
`timescale 1ns / 1ps
// ach_pkg: shared constants and types for the alpha curve hermite spline block
// no dependencies; used by the top level, its checker and the bench

package ach_pkg;

    // default query width and fixed widths of the register fields
    localparam int QUERY_BITS_DEF = 16;
    localparam int ALPHA_BITS     = 8;
    localparam int FOCUS_BITS     = 10;
    localparam int CONC_BITS      = 12;
    localparam int SLOPE_BITS     = 16;
    localparam int CFG_IDX_BITS   = 3;

    // fixed point: t is Q0.16, t = 1.0 needs one more bit
    localparam int FRAC_BITS = 16;
    localparam int T_BITS    = FRAC_BITS + 1;

    // register reset values
    localparam int RES_RESET                    = 255;
    localparam logic [ALPHA_BITS-1:0] FLOOR_RST = 8'd0;
    localparam logic [ALPHA_BITS-1:0] CEIL_RST  = 8'd255;
    localparam logic [FOCUS_BITS-1:0] FOCUS_RST = 10'd512;
    localparam logic [CONC_BITS-1:0] CONC_RST   = 12'd0;
    localparam logic [SLOPE_BITS-1:0] SLOPE_RST = 16'hFFFF;

    // clamp limits
    localparam logic [ALPHA_BITS-1:0] ALPHA_MAX        = 8'd255;
    localparam logic [FOCUS_BITS-1:0] FOCUS_MIN        = 10'd205;
    localparam logic [FOCUS_BITS-1:0] FOCUS_MAX        = 10'd819;
    localparam logic signed [CONC_BITS-1:0] CONC_POS   = 12'sd1024;
    localparam logic signed [CONC_BITS-1:0] CONC_NEG   = -12'sd1024;
    localparam logic [CONC_BITS-2:0] CONC_ONE          = 11'd1024;

    // register index map
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_RESOLUTION  = 3'd0,
        CFG_FLOOR       = 3'd1,
        CFG_CEILING     = 3'd2,
        CFG_FOCUS       = 3'd3,
        CFG_CONCAVITY   = 3'd4,
        CFG_START_SLOPE = 3'd5,
        CFG_END_SLOPE   = 3'd6
    } cfg_reg_t;

endpackage

>>> rtl/alpha_curve_hermite_spline.sv
`timescale 1ns / 1ps
// alpha_curve_hermite_spline: two-segment cubic hermite alpha curve, fully pipelined
// depends on ach_pkg
// pipeline from accepted query word to result word:
//   (2 setup stages, 17 stages of the t divider, 4 polynomial stages, output register)
// throughput: one word per cycle; the whole pipe stalls only while the output word waits
// reset: aresetn synchronous active low, clears valid bits and loads register defaults

module alpha_curve_hermite_spline #(
    parameter int QUERY_BITS = ach_pkg::QUERY_BITS_DEF,
    localparam int CFG_W = (QUERY_BITS > ach_pkg::SLOPE_BITS) ? QUERY_BITS
                                                              : ach_pkg::SLOPE_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [ach_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [CFG_W-1:0]                      cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [QUERY_BITS:0]            s_query_pos,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [ach_pkg::ALPHA_BITS-1:0]        m_alpha_value
);
    import ach_pkg::*;

    localparam int QB = QUERY_BITS;
    localparam int DV = T_BITS;

    // configuration registers
    logic [QB-1:0]               resolution_reg;
    logic [ALPHA_BITS-1:0]       floor_level_reg;
    logic [ALPHA_BITS-1:0]       ceiling_level_reg;
    logic [FOCUS_BITS-1:0]       focus_frac_reg;
    logic signed [CONC_BITS-1:0] concavity_frac_reg;
    logic signed [SLOPE_BITS-1:0] start_slope_reg;
    logic signed [SLOPE_BITS-1:0] end_slope_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resolution_reg     <= QB'(RES_RESET);
            floor_level_reg    <= FLOOR_RST;
            ceiling_level_reg  <= CEIL_RST;
            focus_frac_reg     <= FOCUS_RST;
            concavity_frac_reg <= CONC_RST;
            start_slope_reg    <= SLOPE_RST;
            end_slope_reg      <= SLOPE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_RESOLUTION:  resolution_reg     <= cfg_wdata[QB-1:0];
                CFG_FLOOR:       floor_level_reg    <= cfg_wdata[ALPHA_BITS-1:0];
                CFG_CEILING:     ceiling_level_reg  <= cfg_wdata[ALPHA_BITS-1:0];
                CFG_FOCUS:       focus_frac_reg     <= cfg_wdata[FOCUS_BITS-1:0];
                CFG_CONCAVITY:   concavity_frac_reg <= cfg_wdata[CONC_BITS-1:0];
                CFG_START_SLOPE: start_slope_reg    <= cfg_wdata[SLOPE_BITS-1:0];
                CFG_END_SLOPE:   end_slope_reg      <= cfg_wdata[SLOPE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // clamped register values; the user must keep them stable while words are in flight, the block does not enforce it
    logic                        cf_inv;
    logic [ALPHA_BITS-1:0]       cf_lo;
    logic [ALPHA_BITS-1:0]       cf_hi;
    logic [ALPHA_BITS-1:0]       cf_range;
    logic [FOCUS_BITS-1:0]       cf_foc;
    logic signed [CONC_BITS-1:0] cf_conc;
    logic [CONC_BITS-2:0]        cf_conc_abs;

    always_comb begin
        cf_inv   = ceiling_level_reg < floor_level_reg;
        cf_lo    = cf_inv ? '0 : floor_level_reg;
        cf_hi    = cf_inv ? ALPHA_MAX : ceiling_level_reg;
        cf_range = cf_hi - cf_lo;
        if (focus_frac_reg < FOCUS_MIN) begin
            cf_foc = FOCUS_MIN;
        end else if (focus_frac_reg > FOCUS_MAX) begin
            cf_foc = FOCUS_MAX;
        end else begin
            cf_foc = focus_frac_reg;
        end
        if (concavity_frac_reg > CONC_POS) begin
            cf_conc = CONC_POS;
        end else if (concavity_frac_reg < CONC_NEG) begin
            cf_conc = CONC_NEG;
        end else begin
            cf_conc = concavity_frac_reg;
        end
        cf_conc_abs = cf_conc[CONC_BITS-1] ? (CONC_BITS-1)'(-cf_conc)
                                           : (CONC_BITS-1)'(cf_conc);
    end

    // global advance: the pipe moves whenever the output register is empty or being taken
    logic adv;
    logic m_valid_reg;
    logic [ALPHA_BITS-1:0] m_alpha_value_reg;

    assign adv           = !m_valid_reg || m_ready;
    assign s_ready       = adv;
    assign m_valid       = m_valid_reg;
    assign m_alpha_value = m_alpha_value_reg;

    // stage 1: clamp query, split point
    logic                   s1_valid_reg;
    logic [QB-1:0]          s1_qc_reg, s1_qc_next;
    logic [QB-1:0]          s1_half_reg, s1_half_next;
    logic [QB+FOCUS_BITS-1:0] s1_half_prod;

    always_comb begin
        if (s_query_pos[QB]) begin
            s1_qc_next = '0;
        end else if (s_query_pos[QB-1:0] > resolution_reg) begin
            s1_qc_next = resolution_reg;
        end else begin
            s1_qc_next = s_query_pos[QB-1:0];
        end
        s1_half_prod = (QB+FOCUS_BITS)'(resolution_reg) * (QB+FOCUS_BITS)'(cf_foc);
        s1_half_next = s1_half_prod[QB+FOCUS_BITS-1:FOCUS_BITS];
    end

    // stage 2: segment select, offset and span, center numerator
    logic                   s2_valid_reg;
    logic                   s2_upper_reg, s2_upper_next;
    logic [QB-1:0]          s2_dx_reg, s2_dx_next;
    logic [QB-1:0]          s2_span_reg, s2_span_next;
    logic [QB+ALPHA_BITS-1:0] s2_num_reg, s2_num_next;

    always_comb begin
        s2_upper_next = s1_qc_reg > s1_half_reg;
        s2_dx_next    = s2_upper_next ? (s1_qc_reg - s1_half_reg) : s1_qc_reg;
        s2_span_next  = s2_upper_next ? (resolution_reg - s1_half_reg) : s1_half_reg;
        s2_num_next   = (QB+ALPHA_BITS)'(cf_range) * (QB+ALPHA_BITS)'(s1_half_reg);
    end

    // divider stages: t = (dx << 16) / span, one quotient bit per stage;
    // the center quotient (range * half / resolution) runs in the first 8
    logic                  dv_valid_reg [0:DV-1];
    logic                  dv_upper_reg [0:DV-1];
    logic [QB-1:0]         dv_span_reg  [0:DV-1];
    logic [QB-1:0]         dv_trem_reg  [0:DV-1];
    logic [DV-1:0]         dv_tq_reg    [0:DV-1];
    logic [QB-1:0]         dv_crem_reg  [0:DV-1];
    logic [ALPHA_BITS-1:0] dv_clo_reg   [0:DV-1];
    logic [ALPHA_BITS-1:0] dv_cq_reg    [0:DV-1];

    logic                  dv_upper_in [0:DV-1];
    logic [QB-1:0]         dv_span_in  [0:DV-1];
    logic [QB:0]           dv_tsh      [0:DV-1];
    logic [DV-1:0]         dv_tq_in    [0:DV-1];
    logic [QB-1:0]         dv_crem_in  [0:DV-1];
    logic [ALPHA_BITS-1:0] dv_clo_in   [0:DV-1];
    logic [ALPHA_BITS-1:0] dv_cq_in    [0:DV-1];
    logic [QB:0]           dv_csh      [0:DV-1];

    logic                  dv_tbit     [0:DV-1];
    logic                  dv_cbit     [0:DV-1];
    logic [QB-1:0]         dv_trem_next[0:DV-1];
    logic [DV-1:0]         dv_tq_next  [0:DV-1];
    logic [QB-1:0]         dv_crem_next[0:DV-1];
    logic [ALPHA_BITS-1:0] dv_clo_next [0:DV-1];
    logic [ALPHA_BITS-1:0] dv_cq_next  [0:DV-1];

    // stage inputs
    always_comb begin
        dv_upper_in[0] = s2_upper_reg;
        dv_span_in[0]  = s2_span_reg;
        dv_tsh[0]      = {1'b0, s2_dx_reg};
        dv_tq_in[0]    = '0;
        dv_crem_in[0]  = s2_num_reg[QB+ALPHA_BITS-1:ALPHA_BITS];
        dv_clo_in[0]   = s2_num_reg[ALPHA_BITS-1:0];
        dv_cq_in[0]    = '0;
        for (int k = 1; k < DV; k++) begin
            dv_upper_in[k] = dv_upper_reg[k-1];
            dv_span_in[k]  = dv_span_reg[k-1];
            dv_tsh[k]      = {dv_trem_reg[k-1], 1'b0};
            dv_tq_in[k]    = dv_tq_reg[k-1];
            dv_crem_in[k]  = dv_crem_reg[k-1];
            dv_clo_in[k]   = dv_clo_reg[k-1];
            dv_cq_in[k]    = dv_cq_reg[k-1];
        end
    end

    // one restoring step per stage
    always_comb begin
        for (int k = 0; k < DV; k++) begin
            dv_tbit[k]      = dv_tsh[k] >= {1'b0, dv_span_in[k]};
            dv_trem_next[k] = dv_tbit[k] ? QB'(dv_tsh[k] - {1'b0, dv_span_in[k]})
                                         : QB'(dv_tsh[k]);
            dv_tq_next[k]   = {dv_tq_in[k][DV-2:0], dv_tbit[k]};
            dv_csh[k]       = {dv_crem_in[k], dv_clo_in[k][ALPHA_BITS-1]};
            if (k < ALPHA_BITS) begin
                dv_cbit[k]      = dv_csh[k] >= {1'b0, resolution_reg};
                dv_crem_next[k] = dv_cbit[k] ? QB'(dv_csh[k] - {1'b0, resolution_reg})
                                             : QB'(dv_csh[k]);
                dv_clo_next[k]  = {dv_clo_in[k][ALPHA_BITS-2:0], 1'b0};
                dv_cq_next[k]   = {dv_cq_in[k][ALPHA_BITS-2:0], dv_cbit[k]};
            end else begin
                dv_cbit[k]      = 1'b0;
                dv_crem_next[k] = dv_crem_in[k];
                dv_clo_next[k]  = dv_clo_in[k];
                dv_cq_next[k]   = dv_cq_in[k];
            end
        end
    end

    // stage E1: center, concavity push, t squared
    logic                         e1_valid_reg;
    logic                         e1_upper_reg;
    logic [DV-1:0]                e1_t_reg, e1_t_next;
    logic [DV-1:0]                e1_t2_reg, e1_t2_next;
    logic [ALPHA_BITS-1:0]        e1_center_reg, e1_center_next;
    logic signed [20:0]           e1_cd_reg, e1_cd_next;
    logic [ALPHA_BITS-1:0]        e1_delta;
    logic [2*DV-1:0]              e1_tsq;

    always_comb begin
        e1_t_next      = (dv_span_reg[DV-1] == '0) ? '0 : dv_tq_reg[DV-1];
        e1_center_next = cf_lo + ((resolution_reg == '0) ? '0 : dv_cq_reg[DV-1]);
        e1_delta       = cf_conc[CONC_BITS-1] ? (cf_hi - e1_center_next)
                                              : (e1_center_next - cf_lo);
        e1_cd_next     = 21'(cf_conc) * 21'($signed({1'b0, e1_delta}));
        e1_tsq         = (2*DV)'(e1_t_next) * (2*DV)'(e1_t_next);
        e1_t2_next     = e1_tsq[FRAC_BITS+DV-1:FRAC_BITS];
    end

    // stage E2: mid point with clamp, mid tangent, t cubed
    logic                         e2_valid_reg;
    logic                         e2_upper_reg;
    logic [DV-1:0]                e2_t_reg, e2_t2_reg;
    logic [DV-1:0]                e2_t3_reg, e2_t3_next;
    logic [23:0]                  e2_y1_reg, e2_y1_next;
    logic [23:0]                  e2_vy1_reg, e2_vy1_next;
    logic signed [28:0]           e2_y1raw;
    logic [2*DV-1:0]              e2_tcube;
    logic [18:0]                  e2_vy1_prod;

    always_comb begin
        e2_y1raw = $signed({5'b0, e1_center_reg, 16'b0})
                 - $signed({{2{e1_cd_reg[20]}}, e1_cd_reg, 6'b0});
        if (e2_y1raw > $signed({5'b0, cf_hi, 16'b0})) begin
            e2_y1_next = {cf_hi, 16'b0};
        end else if (e2_y1raw < $signed({5'b0, cf_lo, 16'b0})) begin
            e2_y1_next = {cf_lo, 16'b0};
        end else begin
            e2_y1_next = e2_y1raw[23:0];
        end
        e2_vy1_prod = 19'(cf_range) * 19'(CONC_ONE - cf_conc_abs);
        e2_vy1_next = {e2_vy1_prod, 5'b0};
        e2_tcube    = (2*DV)'(e1_t2_reg) * (2*DV)'(e1_t_reg);
        e2_t3_next  = e2_tcube[FRAC_BITS+DV-1:FRAC_BITS];
    end

    // stage E3: segment end points, tangents and cubic coefficients
    logic                         e3_valid_reg;
    logic [DV-1:0]                e3_t_reg, e3_t2_reg, e3_t3_reg;
    logic [23:0]                  e3_p0_reg, e3_p0_next;
    logic [30:0]                  e3_m0_reg, e3_m0_next;
    logic signed [34:0]           e3_b_reg, e3_b_next;
    logic signed [33:0]           e3_c_reg, e3_c_next;
    logic [23:0]                  e3_p1;
    logic [30:0]                  e3_m1, e3_vy0, e3_vy2;
    logic signed [24:0]           e3_dp;

    always_comb begin
        e3_vy0 = start_slope_reg[SLOPE_BITS-1] ? {7'b0, e2_y1_reg - {cf_lo, 16'b0}}
                                               : {start_slope_reg[SLOPE_BITS-2:0], 16'b0};
        e3_vy2 = end_slope_reg[SLOPE_BITS-1] ? {7'b0, {cf_hi, 16'b0} - e2_y1_reg}
                                             : {end_slope_reg[SLOPE_BITS-2:0], 16'b0};
        if (e2_upper_reg) begin
            e3_p0_next = e2_y1_reg;
            e3_p1      = {cf_hi, 16'b0};
            e3_m0_next = {7'b0, e2_vy1_reg};
            e3_m1      = e3_vy2;
        end else begin
            e3_p0_next = {cf_lo, 16'b0};
            e3_p1      = e2_y1_reg;
            e3_m0_next = e3_vy0;
            e3_m1      = {7'b0, e2_vy1_reg};
        end
        e3_dp     = $signed({1'b0, e3_p1}) - $signed({1'b0, e3_p0_next});
        e3_b_next = ($signed({{10{e3_dp[24]}}, e3_dp}) * 35'sd3)
                  - $signed({3'b0, e3_m0_next, 1'b0}) - $signed({4'b0, e3_m1});
        e3_c_next = $signed({3'b0, e3_m0_next}) + $signed({3'b0, e3_m1})
                  - $signed({{8{e3_dp[24]}}, e3_dp, 1'b0});
    end

    // stage E4: the three products
    logic                         e4_valid_reg;
    logic [23:0]                  e4_p0_reg;
    logic [47:0]                  e4_pa_reg, e4_pa_next;
    logic signed [51:0]           e4_pb_reg, e4_pb_next;
    logic signed [51:0]           e4_pc_reg, e4_pc_next;

    always_comb begin
        e4_pa_next = 48'(e3_m0_reg) * 48'(e3_t_reg);
        e4_pb_next = 52'(e3_b_reg) * 52'($signed({1'b0, e3_t2_reg}));
        e4_pc_next = 52'(e3_c_reg) * 52'($signed({1'b0, e3_t3_reg}));
    end

    // output stage: sum with 32 fraction bits, integer part, clamp
    logic signed [53:0]           out_acc;
    logic signed [21:0]           out_yt;
    logic [ALPHA_BITS-1:0]        out_alpha_next;

    always_comb begin
        out_acc = $signed({14'b0, e4_p0_reg, 16'b0}) + $signed({6'b0, e4_pa_reg})
                + 54'(e4_pb_reg) + 54'(e4_pc_reg);
        out_yt  = out_acc[53:32];
        if (out_yt < $signed({14'b0, cf_lo})) begin
            out_alpha_next = cf_lo;
        end else if (out_yt > $signed({14'b0, cf_hi})) begin
            out_alpha_next = cf_hi;
        end else begin
            out_alpha_next = out_yt[ALPHA_BITS-1:0];
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int k = 0; k < DV; k++) dv_valid_reg[k] <= 1'b0;
            e1_valid_reg <= 1'b0;
            e2_valid_reg <= 1'b0;
            e3_valid_reg <= 1'b0;
            e4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s1_valid_reg    <= s_valid;
            s2_valid_reg    <= s1_valid_reg;
            dv_valid_reg[0] <= s2_valid_reg;
            for (int k = 1; k < DV; k++) dv_valid_reg[k] <= dv_valid_reg[k-1];
            e1_valid_reg <= dv_valid_reg[DV-1];
            e2_valid_reg <= e1_valid_reg;
            e3_valid_reg <= e2_valid_reg;
            e4_valid_reg <= e3_valid_reg;
            m_valid_reg  <= e4_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_qc_reg    <= s1_qc_next;
            s1_half_reg  <= s1_half_next;
            s2_upper_reg <= s2_upper_next;
            s2_dx_reg    <= s2_dx_next;
            s2_span_reg  <= s2_span_next;
            s2_num_reg   <= s2_num_next;
            for (int k = 0; k < DV; k++) begin
                dv_upper_reg[k] <= dv_upper_in[k];
                dv_span_reg[k]  <= dv_span_in[k];
                dv_trem_reg[k]  <= dv_trem_next[k];
                dv_tq_reg[k]    <= dv_tq_next[k];
                dv_crem_reg[k]  <= dv_crem_next[k];
                dv_clo_reg[k]   <= dv_clo_next[k];
                dv_cq_reg[k]    <= dv_cq_next[k];
            end
            e1_upper_reg  <= dv_upper_reg[DV-1];
            e1_t_reg      <= e1_t_next;
            e1_t2_reg     <= e1_t2_next;
            e1_center_reg <= e1_center_next;
            e1_cd_reg     <= e1_cd_next;
            e2_upper_reg  <= e1_upper_reg;
            e2_t_reg      <= e1_t_reg;
            e2_t2_reg     <= e1_t2_reg;
            e2_t3_reg     <= e2_t3_next;
            e2_y1_reg     <= e2_y1_next;
            e2_vy1_reg    <= e2_vy1_next;
            e3_t_reg      <= e2_t_reg;
            e3_t2_reg     <= e2_t2_reg;
            e3_t3_reg     <= e2_t3_reg;
            e3_p0_reg     <= e3_p0_next;
            e3_m0_reg     <= e3_m0_next;
            e3_b_reg      <= e3_b_next;
            e3_c_reg      <= e3_c_next;
            e4_p0_reg     <= e3_p0_reg;
            e4_pa_reg     <= e4_pa_next;
            e4_pb_reg     <= e4_pb_next;
            e4_pc_reg     <= e4_pc_next;
            m_alpha_value_reg <= out_alpha_next;
        end
    end

endmodule

>>> rtl/ach_checker.sv
`timescale 1ns / 1ps
// ach_checker: port-level assertions for alpha_curve_hermite_spline
// depends on ach_pkg; bound to the top level at the end of this file

module ach_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [ach_pkg::ALPHA_BITS-1:0]   m_alpha_value
);
    import ach_pkg::*;

    // a stalled result word holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_alpha_value))
        else $error("result word changed while stalled");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    // with no result waiting, input is always taken
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // a taken result lets the pipe advance in the same cycle
    a_ready_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |-> s_ready)
        else $error("input stalled while output drains");

    // ready is only withheld behind a waiting result word
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |-> m_valid && !m_ready && (m_alpha_value <= ALPHA_MAX))
        else $error("input stalled without output back-pressure");

endmodule

bind alpha_curve_hermite_spline ach_checker u_ach_checker (.*);

>>> sim/tb_alpha_curve_hermite_spline.sv
`timescale 1ns / 1ps
// tb_alpha_curve_hermite_spline: self-checking bench for the two-segment hermite alpha curve
// depends on ach_pkg and alpha_curve_hermite_spline; predicts each alpha word in fixed point

module tb_alpha_curve_hermite_spline;
    import ach_pkg::*;

    localparam int QB = QUERY_BITS_DEF;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED = 3'd7;
    localparam int DRAIN_CYCLES = 40;
    localparam longint ONE_Q16 = 64'sd65536;
    localparam longint ONE_Q32 = 64'sd65536 * 64'sd65536;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [15:0]             cfg_wdata = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [QB:0]      s_query_pos = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [ALPHA_BITS-1:0]   m_alpha_value;

    alpha_curve_hermite_spline dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_query_pos(s_query_pos),
        .m_valid(m_valid), .m_ready(m_ready), .m_alpha_value(m_alpha_value)
    );

    always #6 aclk = ~aclk;

    // shadow copy of the curve registers
    bit [15:0]        cur_res   = 16'(RES_RESET);
    bit [7:0]         cur_floor = FLOOR_RST;
    bit [7:0]         cur_ceil  = CEIL_RST;
    bit [9:0]         cur_focus = FOCUS_RST;
    bit signed [11:0] cur_conc  = CONC_RST;
    bit signed [15:0] cur_start = SLOPE_RST;
    bit signed [15:0] cur_end   = SLOPE_RST;

    logic [7:0] alpha_expected[$];
    bit         failed = 0;
    bit         quiet = 0;
    bit         hold_req = 0;
    int         idle_pct = 12;

    // cubic hermite sum in 32 fraction bits, truncated toward zero
    function automatic longint hermite_eval(longint p0, longint p1, longint m0, longint m1,
                                            longint t);
        longint t2, t3, b, c, acc;
        t2 = (t * t) / ONE_Q16;
        t3 = (t2 * t) / ONE_Q16;
        b = 3 * (p1 - p0) - (2 * m0 + m1);
        c = 2 * (p0 - p1) + (m0 + m1);
        acc = p0 * ONE_Q16 + m0 * t + b * t2 + c * t3;
        return acc / ONE_Q32;
    endfunction

    // alpha value for a query under the current registers
    function automatic logic [7:0] alpha_at(logic signed [QB:0] qin);
        longint res, lo, hi, foc, conc, ss, es, q, half, t, center, delta;
        longint c16, absc, y0, y1, y2, v0, v1, v2, yt;
        res = cur_res; lo = cur_floor; hi = cur_ceil; foc = cur_focus;
        conc = cur_conc; ss = cur_start; es = cur_end; q = qin;
        if (hi < lo) begin
            lo = 0;
            hi = 255;
        end
        if (conc > 1024) conc = 1024;
        if (conc < -1024) conc = -1024;
        if (q > res) q = res;
        if (q < 0) q = 0;
        if (foc < 205) foc = 205;
        if (foc > 819) foc = 819;
        half = (res * foc) / 1024;
        if (q > half) t = ((q - half) * ONE_Q16) / (res - half);
        else if (half == 0) t = 0;
        else t = (q * ONE_Q16) / half;
        center = lo + ((res == 0) ? 0 : ((hi - lo) * half) / res);
        delta = (conc < 0) ? (hi - center) : (center - lo);
        c16 = conc * 64;
        y0 = lo * ONE_Q16;
        y2 = hi * ONE_Q16;
        y1 = center * ONE_Q16 - c16 * delta;
        if (y1 > y2) y1 = y2;
        if (y1 < y0) y1 = y0;
        absc = (c16 < 0) ? -c16 : c16;
        v0 = y1 - y0;
        v1 = ((hi - lo) * (ONE_Q16 - absc)) / 2;
        v2 = y2 - y1;
        if (ss >= 0) v0 = ss * ONE_Q16;
        if (es >= 0) v2 = es * ONE_Q16;
        if (q <= half) yt = hermite_eval(y0, y1, v0, v1, t);
        else yt = hermite_eval(y1, y2, v1, v2, t);
        if (yt < lo) yt = lo;
        if (yt > hi) yt = hi;
        return yt[7:0];
    endfunction

    // one register write per clock; caller lowers the enable after a batch
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        case (idx)
            CFG_RESOLUTION:  cur_res   = v;
            CFG_FLOOR:       cur_floor = v[7:0];
            CFG_CEILING:     cur_ceil  = v[7:0];
            CFG_FOCUS:       cur_focus = v[9:0];
            CFG_CONCAVITY:   cur_conc  = v[11:0];
            CFG_START_SLOPE: cur_start = v;
            CFG_END_SLOPE:   cur_end   = v;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // offer one query word, record its expected alpha once accepted
    task automatic send_query(logic signed [QB:0] q, bit fixed, logic [7:0] fixed_val);
        s_valid <= 1'b1;
        s_query_pos <= q;
        do @(posedge aclk); while (!s_ready);
        alpha_expected.push_back(fixed ? fixed_val : alpha_at(q));
        if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    // stop offering, wait until every word is back and then idle
    task automatic drain();
        s_valid <= 1'b0;
        while (alpha_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic signed [QB:0] pick_query();
        if ($urandom_range(0, 3) != 0) return (QB+1)'($urandom_range(0, cur_res));
        return (QB+1)'($urandom);
    endfunction

    // receiver: check words, random stalls and one long hold-off
    initial begin
        int rx_gap;
        rx_gap = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (alpha_expected.size() == 0) begin
                    $display("%0t: unexpected alpha word %0d", $time, m_alpha_value);
                    failed = 1;
                end else begin
                    logic [7:0] want;
                    want = alpha_expected.pop_front();
                    if (m_alpha_value !== want) begin
                        $display("%0t: alpha mismatch expected %0d actual %0d",
                                 $time, want, m_alpha_value);
                        failed = 1;
                    end
                end
            end
            if (hold_req) begin
                rx_gap = 300;
                hold_req = 0;
            end else if (rx_gap == 0 && !quiet && $urandom_range(0, 99) < idle_pct) begin
                rx_gap = $urandom_range(1, 19);
            end
            if (rx_gap > 0) begin
                m_ready <= 1'b0;
                rx_gap--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    typedef struct {
        logic signed [QB:0] q;
        bit                 fixed;
        logic [7:0]         val;
    } query_row_t;

    // directed queries under reset registers; extremes carry a typed-in alpha
    query_row_t reset_rows[] = '{
        '{17'sd0, 1, 8'd0}, '{17'sd255, 1, 8'd255}, '{17'sh10000, 1, 8'd0},
        '{17'sd65535, 1, 8'd255}, '{-17'sd1, 1, 8'd0}, '{17'sd128, 0, 8'd0},
        '{17'sd127, 0, 8'd0}, '{17'sd64, 0, 8'd0}, '{17'sd200, 0, 8'd0}
    };

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (reset_rows[i]) send_query(reset_rows[i].q, reset_rows[i].fixed, reset_rows[i].val);
        drain();

        // directed settings: inverted limits, clamps, overrides, tiny ranges
        for (int k = 0; k < 8; k++) begin
            case (k)
                0: begin
                    write_reg(CFG_FLOOR, 16'd200);
                    write_reg(CFG_CEILING, 16'd50);
                end
                1: begin
                    write_reg(CFG_FLOOR, 16'd10);
                    write_reg(CFG_CEILING, 16'd240);
                    write_reg(CFG_FOCUS, 16'd0);
                    write_reg(CFG_CONCAVITY, 16'h07FF);
                end
                2: begin
                    write_reg(CFG_FOCUS, 16'd1023);
                    write_reg(CFG_CONCAVITY, 16'h0800);
                end
                3: begin
                    write_reg(CFG_START_SLOPE, 16'd0);
                    write_reg(CFG_END_SLOPE, 16'h7FFF);
                end
                4: begin
                    write_reg(CFG_START_SLOPE, 16'h7FFF);
                    write_reg(CFG_END_SLOPE, 16'd0);
                    write_reg(CFG_RESOLUTION, 16'd0);
                end
                5: write_reg(CFG_RESOLUTION, 16'd1);
                6: begin
                    write_reg(CFG_RESOLUTION, 16'hFFFF);
                    write_reg(CFG_START_SLOPE, 16'h8000);
                    write_reg(CFG_END_SLOPE, 16'hFFFF);
                end
                default: write_reg(CFG_UNMAPPED, 16'h1234);
            endcase
            end_writes();
            send_query('0, 0, '0);
            send_query({1'b0, 16'(cur_res / 3)}, 0, '0);
            send_query({1'b0, cur_res}, 0, '0);
            drain();
        end

        // random settings, one long receiver hold-off, quiet last phase
        for (int p = 0; p < 8; p++) begin
            bit edge_cfg;
            edge_cfg = ($urandom_range(0, 2) == 0);
            write_reg(CFG_RESOLUTION, edge_cfg ? ($urandom_range(0, 1) ? 16'hFFFF : 16'd1)
                                               : ($urandom_range(0, 1)
                                                  ? 16'($urandom_range(1, 1023))
                                                  : 16'($urandom)));
            write_reg(CFG_FLOOR, edge_cfg ? 16'd0 : 16'($urandom_range(0, 255)));
            write_reg(CFG_CEILING, edge_cfg ? 16'd255 : 16'($urandom_range(0, 255)));
            write_reg(CFG_FOCUS, 16'($urandom));
            write_reg(CFG_CONCAVITY, 16'($urandom));
            write_reg(CFG_START_SLOPE, $urandom_range(0, 1) ? 16'($urandom_range(0, 600))
                                                            : 16'($urandom));
            write_reg(CFG_END_SLOPE, $urandom_range(0, 1) ? 16'($urandom_range(0, 600))
                                                          : 16'($urandom));
            end_writes();
            idle_pct = (p % 3 == 1) ? 0 : 12;
            quiet = (p == 7);
            for (int n = 0; n < 100; n++) begin
                if (p == 2 && n == 10) hold_req = 1;
                send_query(pick_query(), 0, '0);
            end
            drain();
        end

        if (!failed)
            $display("alpha_curve_hermite_spline regression: pass");
        else
            $display("alpha_curve_hermite_spline regression: fail");
        $finish;
    end

    // hard stop well past the slowest correct run
    initial begin
        #20ms;
        $display("alpha_curve_hermite_spline regression: fail");
        $finish;
    end

endmodule

>>> alpha_curve_hermite_spline.f
rtl/ach_pkg.sv
rtl/alpha_curve_hermite_spline.sv
rtl/ach_checker.sv
sim/tb_alpha_curve_hermite_spline.sv
